/* sv/luma_threshold_centroid_macros.svh */
// Assertion macros shared by the luma threshold centroid modules.
`ifndef LUMA_THRESHOLD_CENTROID_MACROS_SVH
`define LUMA_THRESHOLD_CENTROID_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define LTC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define LTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ltc_pkg.sv */
// Types and constants shared by the luma threshold centroid modules.
package ltc_pkg;

    localparam int CHAN_W     = 8;
    localparam int WEIGHT_W   = 9;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int NORM_W     = 16;
    localparam int PROD_W     = CHAN_W + WEIGHT_W;
    localparam int LUMA_ACC_W = PROD_W + 2;         // sum of three products
    localparam int DIV_CNT_W  = 4;

    localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd480;
    localparam logic [CHAN_W-1:0]   THRESHOLD_RST    = 8'd215;
    localparam logic [WEIGHT_W-1:0] WEIGHT0_RST      = 9'd77;
    localparam logic [WEIGHT_W-1:0] WEIGHT1_RST      = 9'd150;
    localparam logic [WEIGHT_W-1:0] WEIGHT2_RST      = 9'd29;

    localparam logic KIND_PIXEL    = 1'b0;
    localparam logic KIND_CENTROID = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_LUMA_THRESH   = 3'd2,
        CFG_WEIGHT_CHAN0  = 3'd3,
        CFG_WEIGHT_CHAN1  = 3'd4,
        CFG_WEIGHT_CHAN2  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] chan0;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan2;
    } pixel_t;

    typedef struct packed {
        logic              result_kind;
        logic              white;
        logic              found;
        logic [NORM_W-1:0] norm_x;
        logic [NORM_W-1:0] norm_y;
        logic              last;
    } result_t;

    typedef enum logic [1:0] {
        SEL_CHAN0 = 2'd0,
        SEL_CHAN1 = 2'd1,
        SEL_CHAN2 = 2'd2
    } chan_sel_t;

    typedef enum logic [1:0] {
        DIV_X_AVG  = 2'd0,
        DIV_X_NORM = 2'd1,
        DIV_Y_AVG  = 2'd2,
        DIV_Y_NORM = 2'd3
    } div_op_t;

    typedef struct packed {
        logic      capture;
        logic      mac_step;
        chan_sel_t mac_sel;
        logic      eval;
        logic      div_load;
        logic      div_step;
        logic      div_store;
        div_op_t   div_op;
        logic      cent;
    } ltc_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic out_free;
    } ltc_status_t;

endpackage

/* sv/ltc_ctrl.sv */
// Controller state machine: sequences luma MAC, pixel evaluation and frame-end divisions.
`include "luma_threshold_centroid_macros.svh"

module ltc_ctrl #(
    parameter int MAX_DIM = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ltc_pkg::ltc_status_t status,
    output ltc_pkg::ltc_cmd_t    cmd
);

    localparam int CW = $clog2(MAX_DIM);
    localparam logic [ltc_pkg::DIV_CNT_W-1:0] AVG_LAST  = ltc_pkg::DIV_CNT_W'(CW - 1);
    localparam logic [ltc_pkg::DIV_CNT_W-1:0] NORM_LAST =
        ltc_pkg::DIV_CNT_W'(ltc_pkg::NORM_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_EVAL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_CENT
    } state_t;

    state_t                           state_reg, state_next;
    ltc_pkg::chan_sel_t               mac_sel_reg, mac_sel_next;
    ltc_pkg::div_op_t                 op_reg, op_next;
    logic [ltc_pkg::DIV_CNT_W-1:0]    step_reg, step_next;
    logic [ltc_pkg::DIV_CNT_W-1:0]    step_last;

    assign s_ready = (state_reg == ST_IDLE);

    // averages yield CW quotient bits, normalizations NORM_W bits
    assign step_last = (op_reg == ltc_pkg::DIV_X_AVG || op_reg == ltc_pkg::DIV_Y_AVG) ?
                       AVG_LAST : NORM_LAST;

    always_comb begin
        state_next   = state_reg;
        mac_sel_next = mac_sel_reg;
        op_next      = op_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.mac_sel  = mac_sel_reg;
        cmd.div_op   = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture  = 1'b1;
                    mac_sel_next = ltc_pkg::SEL_CHAN0;
                    state_next   = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mac_step = 1'b1;
                if (mac_sel_reg == ltc_pkg::SEL_CHAN2) begin
                    state_next = ST_EVAL;
                end else begin
                    mac_sel_next = ltc_pkg::chan_sel_t'(mac_sel_reg + 2'd1);
                end
            end
            ST_EVAL: begin
                if (status.out_free) begin
                    cmd.eval = 1'b1;
                    if (status.frame_end) begin
                        op_next    = ltc_pkg::DIV_X_AVG;
                        state_next = ST_DIV_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                if (step_reg == step_last) begin
                    state_next = ST_DIV_STORE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DIV_STORE: begin
                cmd.div_store = 1'b1;
                if (op_reg == ltc_pkg::DIV_Y_NORM) begin
                    state_next = ST_CENT;
                end else begin
                    op_next    = ltc_pkg::div_op_t'(op_reg + 2'd1);
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_CENT: begin
                if (status.out_free) begin
                    cmd.cent   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mac_sel_reg <= ltc_pkg::SEL_CHAN0;
            op_reg      <= ltc_pkg::DIV_X_AVG;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            mac_sel_reg <= mac_sel_next;
            op_reg      <= op_next;
            step_reg    <= step_next;
        end
    end

    `LTC_ASSERT_IMPL(a_load_out_free, cmd.eval || cmd.cent, status.out_free, "result loaded into busy output register")
    `LTC_ASSERT_IMPL(a_idle_no_work, s_ready, !(cmd.mac_step || cmd.div_step || cmd.div_load || cmd.div_store), "datapath work while taking input")
    `LTC_ASSERT_NEXT(a_capture_mac, cmd.capture, cmd.mac_step && cmd.mac_sel == ltc_pkg::SEL_CHAN0, "MAC did not start on channel zero")

endmodule

/* sv/ltc_dp.sv */
// Datapath: config registers, luma MAC, threshold, accumulators, shared divider, output register.
`include "luma_threshold_centroid_macros.svh"

module ltc_dp #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ltc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ltc_pkg::DIM_W-1:0]            cfg_wdata,
    input  ltc_pkg::pixel_t                      s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ltc_pkg::result_t                     m_data,
    input  ltc_pkg::ltc_cmd_t                    cmd,
    output ltc_pkg::ltc_status_t                 status
);

    localparam int CW = $clog2(MAX_DIM);           // column / row / average width
    localparam int NW = 2 * CW + 1;                // white count and remainder width
    localparam int AW = 3 * CW;                    // coordinate sum width
    localparam int QW = (CW > ltc_pkg::NORM_W) ? CW : ltc_pkg::NORM_W;

    // config
    logic [ltc_pkg::DIM_W-1:0]    width_reg, height_reg;
    logic [ltc_pkg::CHAN_W-1:0]   thresh_reg;
    logic [ltc_pkg::WEIGHT_W-1:0] w0_reg, w1_reg, w2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ltc_pkg::FRAME_WIDTH_RST;
            height_reg <= ltc_pkg::FRAME_HEIGHT_RST;
            thresh_reg <= ltc_pkg::THRESHOLD_RST;
            w0_reg     <= ltc_pkg::WEIGHT0_RST;
            w1_reg     <= ltc_pkg::WEIGHT1_RST;
            w2_reg     <= ltc_pkg::WEIGHT2_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ltc_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                ltc_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_wdata;
                ltc_pkg::CFG_LUMA_THRESH:  thresh_reg <= cfg_wdata[ltc_pkg::CHAN_W-1:0];
                ltc_pkg::CFG_WEIGHT_CHAN0: w0_reg     <= cfg_wdata[ltc_pkg::WEIGHT_W-1:0];
                ltc_pkg::CFG_WEIGHT_CHAN1: w1_reg     <= cfg_wdata[ltc_pkg::WEIGHT_W-1:0];
                ltc_pkg::CFG_WEIGHT_CHAN2: w2_reg     <= cfg_wdata[ltc_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: zero reads as one, capped at MAX_DIM
    logic [ltc_pkg::DIM_W-1:0] eff_w, eff_h;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = ltc_pkg::DIM_W'(1);
        end else if (32'(width_reg) > 32'(MAX_DIM)) begin
            eff_w = ltc_pkg::DIM_W'(MAX_DIM);
        end else begin
            eff_w = width_reg;
        end
        if (height_reg == '0) begin
            eff_h = ltc_pkg::DIM_W'(1);
        end else if (32'(height_reg) > 32'(MAX_DIM)) begin
            eff_h = ltc_pkg::DIM_W'(MAX_DIM);
        end else begin
            eff_h = height_reg;
        end
    end

    // luma MAC, one channel per cycle
    ltc_pkg::pixel_t                pix_reg;
    logic [ltc_pkg::LUMA_ACC_W-1:0] luma_acc_reg;
    logic [ltc_pkg::WEIGHT_W-1:0]   mul_w;
    logic [ltc_pkg::CHAN_W-1:0]     mul_c;
    logic [ltc_pkg::PROD_W-1:0]     prod;

    always_comb begin
        case (cmd.mac_sel)
            ltc_pkg::SEL_CHAN0: begin
                mul_w = w0_reg;
                mul_c = pix_reg.chan0;
            end
            ltc_pkg::SEL_CHAN1: begin
                mul_w = w1_reg;
                mul_c = pix_reg.chan1;
            end
            ltc_pkg::SEL_CHAN2: begin
                mul_w = w2_reg;
                mul_c = pix_reg.chan2;
            end
            default: begin
                mul_w = '0;
                mul_c = '0;
            end
        endcase
    end

    assign prod = ltc_pkg::PROD_W'(mul_w) * ltc_pkg::PROD_W'(mul_c);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_reg      <= s_data;
            luma_acc_reg <= '0;
        end else if (cmd.mac_step) begin
            luma_acc_reg <= luma_acc_reg + ltc_pkg::LUMA_ACC_W'(prod);
        end
    end

    // threshold and raster position
    logic [ltc_pkg::LUMA_ACC_W-9:0] luma_full;
    logic [ltc_pkg::CHAN_W-1:0]     luma;
    logic                           is_white;
    logic [CW-1:0]                  col_reg, row_reg;
    logic [CW:0]                    col_inc, row_inc;
    logic                           col_end, row_end;
    logic [AW-1:0]                  xacc_reg, yacc_reg;
    logic [NW-1:0]                  wcnt_reg;

    assign luma_full = luma_acc_reg[ltc_pkg::LUMA_ACC_W-1:8];
    assign luma      = (luma_full > (ltc_pkg::LUMA_ACC_W-8)'(255)) ? 8'hFF :
                       luma_full[ltc_pkg::CHAN_W-1:0];
    assign is_white  = (luma >= thresh_reg);

    assign col_inc = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc = {1'b0, row_reg} + (CW+1)'(1);
    assign col_end = (32'(col_inc) >= 32'(eff_w));
    assign row_end = (32'(row_inc) >= 32'(eff_h));

    assign status.frame_end = col_end && row_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            xacc_reg <= '0;
            yacc_reg <= '0;
            wcnt_reg <= '0;
        end else if (cmd.eval) begin
            if (is_white) begin
                xacc_reg <= xacc_reg + AW'(col_reg);
                yacc_reg <= yacc_reg + AW'(row_reg);
                wcnt_reg <= wcnt_reg + NW'(1);
            end
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_inc[CW-1:0];
            end else begin
                col_reg <= col_inc[CW-1:0];
            end
        end else if (cmd.cent) begin
            xacc_reg <= '0;
            yacc_reg <= '0;
            wcnt_reg <= '0;
        end
    end

    // shared restoring divider, one quotient bit per cycle
    logic [NW-1:0]     rem_reg;
    logic [QW-1:0]     quo_reg;
    logic [NW-1:0]     divisor;
    logic [NW:0]       div_tmp;
    logic [NW:0]       div_diff;
    logic              div_ge;
    logic [CW-1:0]     cx_reg, cy_reg;
    logic [ltc_pkg::NORM_W-1:0] nx_reg, ny_reg;

    always_comb begin
        case (cmd.div_op)
            ltc_pkg::DIV_X_NORM: divisor = NW'(eff_w);
            ltc_pkg::DIV_Y_NORM: divisor = NW'(eff_h);
            default:             divisor = wcnt_reg;
        endcase
    end

    assign div_tmp  = {rem_reg, quo_reg[QW-1]};
    assign div_diff = div_tmp - {1'b0, divisor};
    assign div_ge   = (div_tmp >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            case (cmd.div_op)
                ltc_pkg::DIV_X_AVG: begin
                    rem_reg <= NW'(xacc_reg[AW-1:CW]);
                    quo_reg <= QW'(xacc_reg[CW-1:0]) << (QW - CW);
                end
                ltc_pkg::DIV_Y_AVG: begin
                    rem_reg <= NW'(yacc_reg[AW-1:CW]);
                    quo_reg <= QW'(yacc_reg[CW-1:0]) << (QW - CW);
                end
                ltc_pkg::DIV_X_NORM: begin
                    rem_reg <= NW'(cx_reg);
                    quo_reg <= '0;
                end
                default: begin
                    rem_reg <= NW'(cy_reg);
                    quo_reg <= '0;
                end
            endcase
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? div_diff[NW-1:0] : div_tmp[NW-1:0];
            quo_reg <= {quo_reg[QW-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            case (cmd.div_op)
                ltc_pkg::DIV_X_AVG: cx_reg <= quo_reg[CW-1:0];
                ltc_pkg::DIV_Y_AVG: cy_reg <= quo_reg[CW-1:0];
                ltc_pkg::DIV_X_NORM: begin
                    nx_reg <= (32'(cx_reg) >= 32'(eff_w)) ? '1 :
                              quo_reg[ltc_pkg::NORM_W-1:0];
                end
                default: begin
                    ny_reg <= (32'(cy_reg) >= 32'(eff_h)) ? '1 :
                              quo_reg[ltc_pkg::NORM_W-1:0];
                end
            endcase
        end
    end

    // output register
    ltc_pkg::result_t out_reg;
    logic             m_valid_reg;
    logic             found;

    assign found = (wcnt_reg != '0);

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            out_reg.result_kind <= ltc_pkg::KIND_PIXEL;
            out_reg.white       <= is_white;
            out_reg.found       <= 1'b0;
            out_reg.norm_x      <= '0;
            out_reg.norm_y      <= '0;
            out_reg.last        <= !status.frame_end;
        end else if (cmd.cent) begin
            out_reg.result_kind <= ltc_pkg::KIND_CENTROID;
            out_reg.white       <= 1'b0;
            out_reg.found       <= found;
            out_reg.norm_x      <= found ? nx_reg : '0;
            out_reg.norm_y      <= found ? ny_reg : '0;
            out_reg.last        <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.eval || cmd.cent) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    `LTC_ASSERT_IMPL(a_col_range, 1'b1, 32'(col_reg) < 32'(MAX_DIM), "column counter past MAX_DIM")
    `LTC_ASSERT_NEXT(a_cent_clears, cmd.cent, wcnt_reg == '0 && xacc_reg == '0 && yacc_reg == '0, "accumulators not cleared after centroid")
    `LTC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while waiting")

endmodule

/* sv/luma_threshold_centroid.sv */
// Top level of the luma threshold centroid block: controller plus datapath.
//
//  channel  | handshake              | beat payload
//  ---------+------------------------+----------------------------------------------
//  s_       | s_valid / s_ready      | pixel_t  : chan0, chan1, chan2
//  m_       | m_valid / m_ready      | result_t : result_kind, white, found,
//           |                        |            norm_x, norm_y, last
//  cfg_     | cfg_wr_en (no stall)   | cfg_index selects register, cfg_wdata value
//
// Sequence: a pixel is accepted, takes three MAC steps on the single 9x8 multiplier
//   and is evaluated once the output register is free. A frame-end pixel adds four
//   bit-serial divisions in the shared divider (CW = clog2(MAX_DIM)).
// Reset: aresetn is synchronous, active low; config returns to 640x480, threshold
//   215, weights 77/150/29; counters and accumulators clear. No clearing pass.
// Stalls: the output register holds one result beat; a new pixel is taken while it
//   waits, and the block only stalls before loading the next result.
//
// Luma = (w0*c0 + w1*c1 + w2*c2) >> 8 saturated at 255; white when luma >= threshold.
// Every pixel gives a pixel beat; the frame's last pixel also gives a centroid beat
// (norm = floor(floor(sum/count) * 65536 / dim), Q0.16, saturated), and the
// accumulators then clear. With no white pixel, found and both norms are zero.

module luma_threshold_centroid #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  ltc_pkg::pixel_t               s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output ltc_pkg::result_t              m_data,

    input  logic                          cfg_wr_en,
    input  logic [ltc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ltc_pkg::DIM_W-1:0]     cfg_wdata
);

    ltc_pkg::ltc_cmd_t    cmd;
    ltc_pkg::ltc_status_t status;

    // sequencing: IDLE -> MAC x3 -> EVAL, then on frame end four divisions -> CENT
    ltc_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, state and the output register
    ltc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
